[design/atc_pkg.sv]
`default_nettype none

package atc_pkg;

  // Field widths
  localparam int CALIB_W   = 6;
  localparam int ALPHA_W   = 16;
  localparam int FULL_W    = 15;
  localparam int DZ_W      = 14;
  localparam int TILT_W    = 16;
  localparam int MAG_W     = 15;
  localparam int Q14_FRAC  = 14;
  localparam int TILT_ITER = 15;
  localparam int ADDR_W    = 4;
  localparam int APB_W     = 32;

  localparam logic [MAG_W-1:0] Q14_ONE = MAG_W'(16384);

  // Register reset values
  localparam logic [CALIB_W-1:0] CALIB_RST = CALIB_W'(18);
  localparam logic [ALPHA_W-1:0] ALPHA_RST = ALPHA_W'(11796);
  localparam logic [FULL_W-1:0]  FULL_RST  = FULL_W'(1900);
  localparam logic [DZ_W-1:0]    DZ_RST    = DZ_W'(983);

  // Register indexes
  localparam logic [1:0] REG_CALIB = 2'd0;
  localparam logic [1:0] REG_ALPHA = 2'd1;
  localparam logic [1:0] REG_FULL  = 2'd2;
  localparam logic [1:0] REG_DZ    = 2'd3;

  typedef struct packed {
    logic [CALIB_W-1:0] calib_count;
    logic [ALPHA_W-1:0] filter_alpha;
    logic [FULL_W-1:0]  full_tilt_mm;
    logic [DZ_W-1:0]    dead_zone;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic clear;
    logic accum;
    logic sample;
    logic cal_start;
    logic cal_take;
    logic mul;
    logic add;
    logic tilt_start;
    logic tilt_take;
    logic dz_start;
    logic dz_take;
    logic out_load;
    logic axis;
  } cmd_t;

  typedef struct packed {
    logic recal;
    logic dup;
    logic calibrated;
    logic cal_complete;
    logic div_done;
    logic tilt_short;
    logic dz_short;
  } status_t;

endpackage

`default_nettype wire

[design/accel_tilt_calibrate_filter.sv]
// Accelerometer tilt filter.
// Input channel (in_valid_i / in_stall_o) carries a command bit, X/Y
// acceleration and a timestamp; the output channel (out_valid_o /
// out_stall_i) carries tilt_x, tilt_y, is_calibrated and fresh, one result
// per item. An item is taken on a clock edge with valid high and stall low.
// The block works on one item at a time. Recalibrate, duplicate-timestamp
// and plain calibration items use no division; the item that finishes
// calibration runs two mean divisions, and a filtered item runs up to two
// tilt and two dead-zone divisions of 15 steps on the shared radix-2
// divider; a zero or saturated offset and a tilt inside the dead zone skip
// their division.
// The result sits in an output register: a new item is accepted while it
// waits, and a second result is held back only if it is ready before the
// first is taken. Reset (rst_ni low) clears all filter state and restores
// register defaults. Registers sit on an APB port at 4*index; write them
// only while the block is idle.
`default_nettype none

module accel_tilt_calibrate_filter #(
  parameter int SAMPLE_BITS      = 16,
  parameter int FILTER_FRAC_BITS = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [atc_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [atc_pkg::APB_W-1:0]     pwdata,
  output logic [atc_pkg::APB_W-1:0]          prdata,
  output logic                               pready,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          command_i,
  input  wire logic [SAMPLE_BITS-1:0]        accel_x_i,
  input  wire logic [SAMPLE_BITS-1:0]        accel_y_i,
  input  wire logic [31:0]                   timestamp_us_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [atc_pkg::TILT_W-1:0]         tilt_x_o,
  output logic [atc_pkg::TILT_W-1:0]         tilt_y_o,
  output logic                               is_calibrated_o,
  output logic                               fresh_o
);

  atc_pkg::cfg_t    cfg_q;
  atc_pkg::cmd_t    cmd;
  atc_pkg::status_t status;
  logic             wr_en;
  logic [1:0]       reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.calib_count  <= atc_pkg::CALIB_RST;
      cfg_q.filter_alpha <= atc_pkg::ALPHA_RST;
      cfg_q.full_tilt_mm <= atc_pkg::FULL_RST;
      cfg_q.dead_zone    <= atc_pkg::DZ_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        atc_pkg::REG_CALIB: cfg_q.calib_count  <= pwdata[atc_pkg::CALIB_W-1:0];
        atc_pkg::REG_ALPHA: cfg_q.filter_alpha <= pwdata[atc_pkg::ALPHA_W-1:0];
        atc_pkg::REG_FULL:  cfg_q.full_tilt_mm <= pwdata[atc_pkg::FULL_W-1:0];
        atc_pkg::REG_DZ:    cfg_q.dead_zone    <= pwdata[atc_pkg::DZ_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (reg_idx)
      atc_pkg::REG_CALIB: prdata = atc_pkg::APB_W'(cfg_q.calib_count);
      atc_pkg::REG_ALPHA: prdata = atc_pkg::APB_W'(cfg_q.filter_alpha);
      atc_pkg::REG_FULL:  prdata = atc_pkg::APB_W'(cfg_q.full_tilt_mm);
      atc_pkg::REG_DZ:    prdata = atc_pkg::APB_W'(cfg_q.dead_zone);
      default:            prdata = '0;
    endcase
  end

  atc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  atc_datapath #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .FILTER_FRAC_BITS (FILTER_FRAC_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .cmd_i           (cmd),
    .status_o        (status),
    .command_i       (command_i),
    .accel_x_i       (accel_x_i),
    .accel_y_i       (accel_y_i),
    .timestamp_us_i  (timestamp_us_i),
    .tilt_x_o        (tilt_x_o),
    .tilt_y_o        (tilt_y_o),
    .is_calibrated_o (is_calibrated_o),
    .fresh_o         (fresh_o)
  );

endmodule

`default_nettype wire

[design/atc_divider.sv]
`default_nettype none

module atc_divider #(
  parameter int DW = 23,
  parameter int LW = 23,
  parameter int CW = 5
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] rem_init_i,
  input  wire logic [LW-1:0] low_init_i,
  input  wire logic [DW-1:0] divisor_i,
  input  wire logic [CW-1:0] count_i,
  output logic               done_o,
  output logic [LW-1:0]      quot_o
);

  logic          run_q, run_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [LW-1:0] low_q, low_d;
  logic [LW-1:0] quot_q, quot_d;
  logic [DW-1:0] div_q, div_d;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem_q, low_q[LW-1]};
  assign fits  = trial >= {1'b0, div_q};

  // One quotient bit per cycle, restoring
  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    low_d  = low_q;
    quot_d = quot_q;
    div_d  = div_q;
    if (start_i) begin
      run_d  = 1'b1;
      cnt_d  = count_i;
      rem_d  = rem_init_i;
      low_d  = low_init_i;
      quot_d = '0;
      div_d  = divisor_i;
    end else if (run_q) begin
      rem_d  = fits ? DW'(trial - {1'b0, div_q}) : DW'(trial);
      low_d  = low_q << 1;
      quot_d = {quot_q[LW-2:0], fits};
      cnt_d  = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    low_q  <= low_d;
    quot_q <= quot_d;
    div_q  <= div_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

[design/atc_datapath.sv]
`default_nettype none

module atc_datapath #(
  parameter int SAMPLE_BITS      = 16,
  parameter int FILTER_FRAC_BITS = 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire atc_pkg::cfg_t          cfg_i,
  input  wire atc_pkg::cmd_t          cmd_i,
  output atc_pkg::status_t            status_o,
  input  wire logic                   command_i,
  input  wire logic [SAMPLE_BITS-1:0] accel_x_i,
  input  wire logic [SAMPLE_BITS-1:0] accel_y_i,
  input  wire logic [31:0]            timestamp_us_i,
  output logic [atc_pkg::TILT_W-1:0]  tilt_x_o,
  output logic [atc_pkg::TILT_W-1:0]  tilt_y_o,
  output logic                        is_calibrated_o,
  output logic                        fresh_o
);

  localparam int SB       = SAMPLE_BITS;
  localparam int FB       = FILTER_FRAC_BITS;
  localparam int SUM_W    = SB + 7;
  localparam int SMOOTH_W = SB + FB;
  localparam int D_W      = SMOOTH_W + 1;
  localparam int DEN_W    = atc_pkg::FULL_W + FB;
  localparam int DW       = DEN_W;
  localparam int LW       = SUM_W;
  localparam int CW       = $clog2(LW + 1);
  localparam int PROD_W   = D_W + atc_pkg::ALPHA_W + 1;
  localparam int CMP_W    = D_W + DEN_W + 1;
  localparam int MW       = atc_pkg::MAG_W;
  localparam int TW       = atc_pkg::TILT_W;

  // Architectural state
  logic signed [SUM_W-1:0]    sum_x_q, sum_y_q;
  logic [atc_pkg::CALIB_W-1:0] cnt_q;
  logic signed [SB-1:0]       neutral_x_q, neutral_y_q;
  logic signed [SMOOTH_W-1:0] smooth_x_q, smooth_y_q;
  logic [31:0]                last_stamp_q;
  logic                       calibrated_q;
  logic signed [TW-1:0]       held_x_q, held_y_q;
  // Working registers
  logic                       fresh_q;
  logic signed [SB-1:0]       samp_x_q, samp_y_q;
  logic signed [PROD_W-1:0]   prod_x_q, prod_y_q;
  logic [MW-1:0]              t_mag_q;
  logic                       t_neg_q;
  logic [TW-1:0]              res_x_q, res_y_q;
  logic                       res_cal_q, res_fresh_q;

  // Calibration count check
  logic [atc_pkg::CALIB_W-1:0] cnt_next;
  assign cnt_next = cnt_q + atc_pkg::CALIB_W'(1);

  // Filter arithmetic
  logic signed [D_W-1:0]    diff_x, diff_y;
  logic signed [PROD_W-1:0] alpha_s;
  assign diff_x  = D_W'($signed({samp_x_q, {FB{1'b0}}})) - D_W'(smooth_x_q);
  assign diff_y  = D_W'($signed({samp_y_q, {FB{1'b0}}})) - D_W'(smooth_y_q);
  assign alpha_s = PROD_W'($signed({1'b0, cfg_i.filter_alpha}));

  // Tilt offset of the selected axis
  logic signed [D_W-1:0] neu_sel, sm_sel, d_sel;
  logic [D_W-1:0]        dmag;
  logic                  d_neg, d_zero, d_sat;
  logic [DEN_W-1:0]      den;
  logic [CMP_W-1:0]      dmag_w;
  assign neu_sel = cmd_i.axis ? D_W'($signed({neutral_y_q, {FB{1'b0}}}))
                              : D_W'($signed({neutral_x_q, {FB{1'b0}}}));
  assign sm_sel  = cmd_i.axis ? D_W'(smooth_y_q) : D_W'(smooth_x_q);
  assign d_sel   = cmd_i.axis ? (sm_sel - neu_sel) : (neu_sel - sm_sel);
  assign d_neg   = d_sel[D_W-1];
  assign dmag    = d_neg ? D_W'(-d_sel) : D_W'(d_sel);
  assign d_zero  = (d_sel == '0);
  assign den     = {cfg_i.full_tilt_mm, {FB{1'b0}}};
  assign dmag_w  = CMP_W'(dmag);
  assign d_sat   = dmag_w >= (CMP_W'(den) << 1);

  // Dead zone
  logic [MW-1:0] dz_w, excess, dz_den;
  assign dz_w   = MW'(cfg_i.dead_zone);
  assign excess = t_mag_q - dz_w;
  assign dz_den = atc_pkg::Q14_ONE - dz_w;

  // Calibration mean
  logic signed [SUM_W-1:0] sum_sel;
  logic [SUM_W-1:0]        sum_mag;
  assign sum_sel = cmd_i.axis ? sum_y_q : sum_x_q;
  assign sum_mag = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);

  // Shared divider
  logic          div_start, div_done;
  logic [DW-1:0] div_rem, div_den;
  logic [LW-1:0] div_low, quot;
  logic [CW-1:0] div_cnt;

  always_comb begin
    div_start = cmd_i.cal_start || (cmd_i.tilt_start && !(d_zero || d_sat)) ||
                (cmd_i.dz_start && !(t_mag_q <= dz_w));
    if (cmd_i.cal_start) begin
      div_rem = '0;
      div_low = sum_mag;
      div_den = DW'(cnt_q);
      div_cnt = CW'(SUM_W);
    end else if (cmd_i.tilt_start) begin
      div_rem = dmag_w[DW:1];
      div_low = LW'({dmag[0], {atc_pkg::Q14_FRAC{1'b0}}}) << (LW - atc_pkg::TILT_ITER);
      div_den = DW'(den);
      div_cnt = CW'(atc_pkg::TILT_ITER);
    end else begin
      div_rem = DW'(excess >> 1);
      div_low = LW'({excess[0], {atc_pkg::Q14_FRAC{1'b0}}}) << (LW - atc_pkg::TILT_ITER);
      div_den = DW'(dz_den);
      div_cnt = CW'(atc_pkg::TILT_ITER);
    end
  end

  atc_divider #(.DW(DW), .LW(LW), .CW(CW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .rem_init_i (div_rem),
    .low_init_i (div_low),
    .divisor_i  (div_den),
    .count_i    (div_cnt),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // Signed results from the quotient
  logic signed [SUM_W-1:0] mean_w;
  logic signed [SB-1:0]    mean;
  logic [MW-1:0]           q_clamped;
  logic signed [TW-1:0]    q_signed;
  assign mean_w    = sum_sel[SUM_W-1] ? SUM_W'(-quot) : SUM_W'(quot);
  assign mean      = SB'(mean_w);
  assign q_clamped = (quot > LW'(atc_pkg::Q14_ONE)) ? atc_pkg::Q14_ONE : MW'(quot);
  assign q_signed  = t_neg_q ? TW'(-quot) : TW'(quot);

  // Status to the controller
  always_comb begin
    status_o.recal        = command_i;
    status_o.dup          = (timestamp_us_i == last_stamp_q);
    status_o.calibrated   = calibrated_q;
    status_o.cal_complete = (cnt_next >= cfg_i.calib_count) && (cnt_next != '0);
    status_o.div_done     = div_done;
    status_o.tilt_short   = d_zero || d_sat;
    status_o.dz_short     = (t_mag_q <= dz_w);
  end

  // State updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_x_q      <= '0;
      sum_y_q      <= '0;
      cnt_q        <= '0;
      neutral_x_q  <= '0;
      neutral_y_q  <= '0;
      smooth_x_q   <= '0;
      smooth_y_q   <= '0;
      last_stamp_q <= '0;
      calibrated_q <= 1'b0;
      held_x_q     <= '0;
      held_y_q     <= '0;
      fresh_q      <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        fresh_q <= cmd_i.accum || cmd_i.sample;
      end
      if (cmd_i.clear) begin
        sum_x_q      <= '0;
        sum_y_q      <= '0;
        cnt_q        <= '0;
        neutral_x_q  <= '0;
        neutral_y_q  <= '0;
        smooth_x_q   <= '0;
        smooth_y_q   <= '0;
        last_stamp_q <= '0;
        calibrated_q <= 1'b0;
        held_x_q     <= '0;
        held_y_q     <= '0;
      end
      if (cmd_i.accum) begin
        sum_x_q      <= sum_x_q + SUM_W'($signed(accel_x_i));
        sum_y_q      <= sum_y_q + SUM_W'($signed(accel_y_i));
        cnt_q        <= cnt_next;
        last_stamp_q <= timestamp_us_i;
      end
      if (cmd_i.sample) begin
        last_stamp_q <= timestamp_us_i;
      end
      if (cmd_i.cal_take) begin
        if (cmd_i.axis) begin
          neutral_y_q  <= mean;
          smooth_y_q   <= {mean, {FB{1'b0}}};
          calibrated_q <= 1'b1;
        end else begin
          neutral_x_q <= mean;
          smooth_x_q  <= {mean, {FB{1'b0}}};
        end
      end
      if (cmd_i.add) begin
        smooth_x_q <= smooth_x_q + SMOOTH_W'(prod_x_q >>> atc_pkg::ALPHA_W);
        smooth_y_q <= smooth_y_q + SMOOTH_W'(prod_y_q >>> atc_pkg::ALPHA_W);
      end
      if ((cmd_i.dz_start && (t_mag_q <= dz_w)) || cmd_i.dz_take) begin
        if (cmd_i.axis) begin
          held_y_q <= cmd_i.dz_take ? q_signed : '0;
        end else begin
          held_x_q <= cmd_i.dz_take ? q_signed : '0;
        end
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.sample) begin
      samp_x_q <= $signed(accel_x_i);
      samp_y_q <= $signed(accel_y_i);
    end
    if (cmd_i.mul) begin
      prod_x_q <= PROD_W'(diff_x) * alpha_s;
      prod_y_q <= PROD_W'(diff_y) * alpha_s;
    end
    if (cmd_i.tilt_start) begin
      t_neg_q <= d_neg;
      if (d_zero) begin
        t_mag_q <= '0;
      end else if (d_sat) begin
        t_mag_q <= atc_pkg::Q14_ONE;
      end
    end
    if (cmd_i.tilt_take) begin
      t_mag_q <= q_clamped;
    end
    if (cmd_i.out_load) begin
      res_x_q     <= held_x_q;
      res_y_q     <= held_y_q;
      res_cal_q   <= calibrated_q;
      res_fresh_q <= fresh_q;
    end
  end

  assign tilt_x_o        = res_x_q;
  assign tilt_y_o        = res_y_q;
  assign is_calibrated_o = res_cal_q;
  assign fresh_o         = res_fresh_q;

endmodule

`default_nettype wire

[design/atc_ctrl.sv]
`default_nettype none

module atc_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  input  wire atc_pkg::status_t status_i,
  output atc_pkg::cmd_t         cmd_o
);

  typedef enum logic [9:0] {
    S_IDLE       = 10'b00_0000_0001,
    S_CAL_START  = 10'b00_0000_0010,
    S_CAL_WAIT   = 10'b00_0000_0100,
    S_FMUL       = 10'b00_0000_1000,
    S_FADD       = 10'b00_0001_0000,
    S_TILT_START = 10'b00_0010_0000,
    S_TILT_WAIT  = 10'b00_0100_0000,
    S_DZ_START   = 10'b00_1000_0000,
    S_DZ_WAIT    = 10'b01_0000_0000,
    S_RESULT     = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   axis_q, axis_d;
  logic   out_valid_q, out_valid_d;

  // Sequence one item through calibration or filter and tilt steps
  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    cmd_o   = '0;
    cmd_o.axis = axis_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (status_i.recal) begin
            cmd_o.clear = 1'b1;
            state_d = S_RESULT;
          end else if (status_i.dup) begin
            state_d = S_RESULT;
          end else if (!status_i.calibrated) begin
            cmd_o.accum = 1'b1;
            axis_d  = 1'b0;
            state_d = status_i.cal_complete ? S_CAL_START : S_RESULT;
          end else begin
            cmd_o.sample = 1'b1;
            state_d = S_FMUL;
          end
        end
      end
      S_CAL_START: begin
        cmd_o.cal_start = 1'b1;
        state_d = S_CAL_WAIT;
      end
      S_CAL_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.cal_take = 1'b1;
          if (axis_q) begin
            state_d = S_RESULT;
          end else begin
            axis_d  = 1'b1;
            state_d = S_CAL_START;
          end
        end
      end
      S_FMUL: begin
        cmd_o.mul = 1'b1;
        state_d = S_FADD;
      end
      S_FADD: begin
        cmd_o.add = 1'b1;
        axis_d  = 1'b0;
        state_d = S_TILT_START;
      end
      S_TILT_START: begin
        cmd_o.tilt_start = 1'b1;
        state_d = status_i.tilt_short ? S_DZ_START : S_TILT_WAIT;
      end
      S_TILT_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.tilt_take = 1'b1;
          state_d = S_DZ_START;
        end
      end
      S_DZ_START: begin
        cmd_o.dz_start = 1'b1;
        if (!status_i.dz_short) begin
          state_d = S_DZ_WAIT;
        end else if (axis_q) begin
          state_d = S_RESULT;
        end else begin
          axis_d  = 1'b1;
          state_d = S_TILT_START;
        end
      end
      S_DZ_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.dz_take = 1'b1;
          if (axis_q) begin
            state_d = S_RESULT;
          end else begin
            axis_d  = 1'b1;
            state_d = S_TILT_START;
          end
        end
      end
      S_RESULT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold the result until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire
